>>> hdl/cft_pkg.sv
// cft_pkg: types, constants and register indexes for the CSV field tokenizer.
// No dependencies; imported by every module of the block.
package cft_pkg;

    localparam int ROW_BITS    = 16;
    localparam int COL_BITS    = 8;
    localparam int Q_DEPTH     = 4;
    localparam int Q_PTR_BITS  = $clog2(Q_DEPTH);
    localparam int PADDR_BITS  = 3;
    localparam int PDATA_BITS  = 32;

    localparam logic [7:0] QUOTE_BYTE = 8'h22;
    localparam logic [7:0] LF_BYTE    = 8'h0A;
    localparam logic [7:0] CR_BYTE    = 8'h0D;
    localparam logic [7:0] SEP_RESET  = 8'd44;

    localparam logic REQ_DATA = 1'b0;
    localparam logic REQ_END  = 1'b1;

    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_END  = 1'b1;

    localparam logic REG_SEPARATOR = 1'b0;
    localparam logic REG_FIRST_ROW = 1'b1;

    typedef struct packed {
        logic       req_type;
        logic [7:0] in_byte;
    } item_t;

    typedef struct packed {
        logic                kind;
        logic [7:0]          out_char;
        logic [ROW_BITS-1:0] row;
        logic [COL_BITS-1:0] column;
        logic                last;
    } result_t;

    typedef struct packed {
        logic    two;
        result_t r0;
        result_t r1;
    } q_entry_t;

    typedef struct packed {
        logic [7:0]  separator;
        logic [15:0] first_row;
    } cfg_t;

    function automatic result_t make_result(logic kind, logic [7:0] ch,
                                            logic [ROW_BITS-1:0] row,
                                            logic [COL_BITS-1:0] column);
        result_t r;
        r.kind     = kind;
        r.out_char = ch;
        r.row      = row;
        r.column   = column;
        r.last     = 1'b0;
        return r;
    endfunction

endpackage

>>> hdl/cft_front.sv
// cft_front: parses one byte per cycle while accept is high, keeps the
// tokenizer state and builds a queue entry of up to two results. Depends on cft_pkg.
module cft_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  cft_pkg::item_t                item,
    input  cft_pkg::cfg_t                 cfg,
    input  logic                          row_load,
    input  logic [cft_pkg::ROW_BITS-1:0]  row_init,
    output logic                          q_push,
    output cft_pkg::q_entry_t             q_entry
);
    import cft_pkg::*;

    logic                in_quotes_reg, in_quotes_next;
    logic                quote_pend_reg, quote_pend_next;
    logic                sep_pend_reg, sep_pend_next;
    logic                skip_sep_reg, skip_sep_next;
    logic                nonempty_reg, nonempty_next;
    logic [ROW_BITS-1:0] row_reg, row_next;
    logic [COL_BITS-1:0] col_reg, col_next;
    logic [1:0]          nres;
    result_t             r0, r1;

    always_comb
    begin
        logic [7:0] b;
        logic       sep_ok, is_q, is_lf, is_cr, is_sep, handled;
        logic       do_sep;
        logic       emit_a, emit_b;
        logic       kind_a, kind_b;
        logic [7:0] ch_a, ch_b;

        b       = item.in_byte;
        sep_ok  = (cfg.separator != QUOTE_BYTE) && (cfg.separator != LF_BYTE) &&
                  (cfg.separator != CR_BYTE);
        is_q    = (b == QUOTE_BYTE);
        is_lf   = (b == LF_BYTE);
        is_cr   = (b == CR_BYTE);
        is_sep  = sep_ok && (b == cfg.separator);
        handled = 1'b0;
        do_sep  = 1'b0;
        emit_a  = 1'b0;
        emit_b  = 1'b0;
        kind_a  = KIND_CHAR;
        kind_b  = KIND_CHAR;
        ch_a    = 8'h00;
        ch_b    = 8'h00;

        in_quotes_next  = in_quotes_reg;
        quote_pend_next = quote_pend_reg;
        sep_pend_next   = sep_pend_reg;
        skip_sep_next   = skip_sep_reg;
        nonempty_next   = nonempty_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        nres            = 2'd0;
        r0              = make_result(KIND_CHAR, 8'h00, row_reg, col_reg);
        r1              = make_result(KIND_CHAR, 8'h00, row_reg, col_reg);

        // first result: a pending separator, or the doubled quote
        if (item.req_type == REQ_END)
        begin
            if (quote_pend_reg)
            begin
                in_quotes_next = 1'b0;
            end
            do_sep = sep_pend_reg;
        end
        else
        begin
            if (quote_pend_reg)
            begin
                skip_sep_next   = 1'b0;
                quote_pend_next = 1'b0;
                if (is_q)
                begin
                    emit_a  = 1'b1;
                    ch_a    = QUOTE_BYTE;
                    handled = 1'b1;
                end
                else
                begin
                    in_quotes_next = 1'b0;
                end
            end
            if (!handled && !is_sep && sep_pend_reg && !is_lf && !is_cr)
            begin
                do_sep = 1'b1;
            end
            if (!handled && !is_sep)
            begin
                sep_pend_next = 1'b0;
            end
        end

        if (do_sep)
        begin
            emit_a = 1'b1;
            if (in_quotes_next)
            begin
                ch_a          = cfg.separator;
                nonempty_next = 1'b1;
            end
            else
            begin
                kind_a        = KIND_END;
                nonempty_next = 1'b0;
            end
        end

        if (emit_a)
        begin
            r0   = make_result(kind_a, ch_a, row_next, col_next);
            nres = 2'd1;
            if (kind_a == KIND_CHAR)
            begin
                nonempty_next = 1'b1;
            end
            else if (col_next != {COL_BITS{1'b1}})
            begin
                col_next = col_next + 1'b1;
            end
        end

        // second part: the byte itself
        if (item.req_type == REQ_END)
        begin
            if (nonempty_next)
            begin
                emit_b = 1'b1;
                kind_b = KIND_END;
            end
        end
        else if (!handled)
        begin
            if (is_sep)
            begin
                if (!skip_sep_next)
                begin
                    sep_pend_next = 1'b1;
                end
            end
            else if (is_q)
            begin
                if (in_quotes_next)
                begin
                    quote_pend_next = 1'b1;
                end
                else
                begin
                    in_quotes_next = 1'b1;
                end
                skip_sep_next = 1'b0;
            end
            else if (is_lf)
            begin
                emit_b = 1'b1;
                if (in_quotes_next)
                begin
                    // quoted newline becomes CR LF
                    r0   = make_result(KIND_CHAR, CR_BYTE, row_next, col_next);
                    nres = 2'd1;
                    ch_b = LF_BYTE;
                end
                else
                begin
                    kind_b = KIND_END;
                end
                skip_sep_next = 1'b1;
            end
            else if (is_cr)
            begin
                skip_sep_next = 1'b1;
            end
            else
            begin
                emit_b        = 1'b1;
                ch_b          = b;
                skip_sep_next = 1'b0;
            end
        end

        if (emit_b)
        begin
            if (nres == 2'd0)
            begin
                r0 = make_result(kind_b, ch_b, row_next, col_next);
            end
            else
            begin
                r1 = make_result(kind_b, ch_b, row_next, col_next);
            end
            nres          = nres + 2'd1;
            nonempty_next = (kind_b == KIND_CHAR);
            if (item.req_type == REQ_DATA && is_lf && kind_b == KIND_END)
            begin
                if (row_next != {ROW_BITS{1'b1}})
                begin
                    row_next = row_next + 1'b1;
                end
                col_next = '0;
            end
        end

        if (item.req_type == REQ_END)
        begin
            in_quotes_next  = 1'b0;
            quote_pend_next = 1'b0;
            sep_pend_next   = 1'b0;
            skip_sep_next   = 1'b1;
            nonempty_next   = 1'b0;
            row_next        = cfg.first_row[ROW_BITS-1:0];
            col_next        = '0;
        end

        r0.last = (nres == 2'd1);
        r1.last = 1'b1;
    end

    assign q_push        = accept && (nres != 2'd0);
    assign q_entry.two   = nres[1];
    assign q_entry.r0    = r0;
    assign q_entry.r1    = r1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_quotes_reg  <= 1'b0;
            quote_pend_reg <= 1'b0;
            sep_pend_reg   <= 1'b0;
            skip_sep_reg   <= 1'b1;
            nonempty_reg   <= 1'b0;
            row_reg        <= '0;
            col_reg        <= '0;
        end
        else
        begin
            if (accept)
            begin
                in_quotes_reg  <= in_quotes_next;
                quote_pend_reg <= quote_pend_next;
                sep_pend_reg   <= sep_pend_next;
                skip_sep_reg   <= skip_sep_next;
                nonempty_reg   <= nonempty_next;
                col_reg        <= col_next;
            end
            if (row_load)
            begin
                row_reg <= row_init;
            end
            else if (accept)
            begin
                row_reg <= row_next;
            end
        end
    end

endmodule

>>> hdl/cft_queue.sv
// cft_queue: short FIFO of result entries between front and back.
// Depends on cft_pkg.
module cft_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  cft_pkg::q_entry_t wr_data,
    input  logic              rd_en,
    output cft_pkg::q_entry_t rd_data,
    output logic              q_full,
    output logic              q_empty
);
    import cft_pkg::*;

    q_entry_t              mem [Q_DEPTH];
    logic [Q_PTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [Q_PTR_BITS:0]   count_reg, count_next;

    assign q_full  = (count_reg == Q_PTR_BITS'(0) + (Q_PTR_BITS+1)'(Q_DEPTH));
    assign q_empty = (count_reg == '0);
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

>>> hdl/cft_back.sv
// cft_back: unpacks queue entries into single results on the result port.
// Depends on cft_pkg.
module cft_back (
    input  logic              clk,
    input  logic              rst_n,
    input  cft_pkg::q_entry_t head,
    input  logic              q_empty,
    output logic              q_pop,
    input  logic              pop,
    output logic              empty,
    output cft_pkg::result_t  result
);
    import cft_pkg::*;

    logic phase_reg, phase_next;
    logic take;

    assign empty  = q_empty;
    assign result = phase_reg ? head.r1 : head.r0;
    assign take   = pop && !q_empty;
    assign q_pop  = take && (phase_reg || !head.two);

    always_comb
    begin
        phase_next = phase_reg;
        if (take)
        begin
            phase_next = head.two && !phase_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

endmodule

>>> hdl/csv_field_tokenizer.sv
// csv_field_tokenizer: accepts one item per cycle while not full; a result is
// registered in the queue and shows once earlier entries are popped. A byte
// with two results takes two pops; a four-entry queue between parser and output
// absorbs it. Sustained rate: one item per cycle while items average at most one
// result and pop is held. rst_n (async, low) clears parser state, queue and
// registers to defaults. Depends on cft_pkg, cft_front, cft_queue, cft_back.
module csv_field_tokenizer (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  cft_pkg::item_t                    item,
    input  logic                              pop,
    output logic                              empty,
    output cft_pkg::result_t                  result,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [cft_pkg::PADDR_BITS-1:0]    paddr,
    input  logic [cft_pkg::PDATA_BITS-1:0]    pwdata,
    output logic [cft_pkg::PDATA_BITS-1:0]    prdata,
    output logic                              pready
);
    import cft_pkg::*;

    cfg_t     cfg_reg;
    logic     wr_sep, wr_row;
    logic     accept;
    logic     q_push, q_pop, q_full, q_empty;
    q_entry_t q_entry, q_head;

    assign pready = 1'b1;
    assign wr_sep = psel && penable && pwrite && (paddr[2] == REG_SEPARATOR);
    assign wr_row = psel && penable && pwrite && (paddr[2] == REG_FIRST_ROW);

    always_comb
    begin
        unique case (paddr[2])
            REG_SEPARATOR: prdata = {24'h0, cfg_reg.separator};
            REG_FIRST_ROW: prdata = {16'h0, cfg_reg.first_row};
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.separator <= SEP_RESET;
            cfg_reg.first_row <= '0;
        end
        else
        begin
            if (wr_sep)
            begin
                cfg_reg.separator <= pwdata[7:0];
            end
            if (wr_row)
            begin
                cfg_reg.first_row <= pwdata[15:0];
            end
        end
    end

    assign full   = q_full;
    assign accept = push && !q_full;

    cft_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .item     (item),
        .cfg      (cfg_reg),
        .row_load (wr_row),
        .row_init (pwdata[ROW_BITS-1:0]),
        .q_push   (q_push),
        .q_entry  (q_entry)
    );

    cft_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_entry),
        .rd_en   (q_pop),
        .rd_data (q_head),
        .q_full  (q_full),
        .q_empty (q_empty)
    );

    cft_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (q_head),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .pop     (pop),
        .empty   (empty),
        .result  (result)
    );

endmodule

>>> hdl/cft_checker.sv
// cft_checker: port-level assertions for csv_field_tokenizer, bound to it.
// Depends on cft_pkg.
module cft_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             push,
    input logic             full,
    input cft_pkg::item_t   item,
    input logic             pop,
    input logic             empty,
    input cft_pkg::result_t result
);
    import cft_pkg::*;

    // a waiting result holds until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("waiting result changed");

    // field end carries no character
    a_end_char: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.kind == KIND_END) |-> (result.out_char == 8'h00))
        else $error("field end with nonzero char");

    // a CR character only comes from a quoted newline, so LF follows it
    a_cr_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.kind == KIND_CHAR && result.out_char == CR_BYTE)
        |-> !result.last)
        else $error("CR char ends an item");

    // the rest of an item is ready right after its first result is taken
    a_item_whole: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && !result.last) |=> !empty)
        else $error("item split by a gap");

    // full only when results are waiting
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !empty)
        else $error("full with nothing to read");

endmodule

bind csv_field_tokenizer cft_checker u_checker (.*);
